FILE: hdl/clhp_pkg.sv
// shared types and constants for the content-length header parser
`default_nettype none
package clhp_pkg;

    localparam int unsigned NAME_LEN = 15;
    localparam logic [8*NAME_LEN-1:0] HDR_NAME = "Content-Length:";
    localparam logic [31:0] ACC_LIMIT = 32'd429496729;
    localparam logic [3:0] DIGIT_LIMIT = 4'd5;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_NAME  = 3'd1,
        PH_SKIP  = 3'd2,
        PH_VALUE = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [NAME_LEN-1:0] name_hit;
        logic                is_ws;
        logic                is_lf;
        logic                is_cr;
        logic                is_digit;
        logic [3:0]          digit;
        logic                last;
    } t_item;

endpackage
`default_nettype wire

FILE: hdl/clhp_front.sv
// front end: accepts header bytes and classifies them
`default_nettype none
module clhp_front (
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_is_last,
    output logic               o_push,
    output clhp_pkg::t_item    o_item,
    input  wire logic          i_full
);
    import clhp_pkg::*;

    always_comb begin
        o_item = '0;
        for (int k = 0; k < NAME_LEN; k++) begin
            o_item.name_hit[k] = (i_data_byte == HDR_NAME[8*(NAME_LEN-1-k) +: 8]);
        end
        o_item.is_ws    = (i_data_byte == 8'h20) || (i_data_byte == 8'h09);
        o_item.is_lf    = (i_data_byte == 8'h0a);
        o_item.is_cr    = (i_data_byte == 8'h0d);
        o_item.is_digit = (i_data_byte >= 8'h30) && (i_data_byte <= 8'h39);
        o_item.digit    = 4'(i_data_byte - 8'h30);
        o_item.last     = i_is_last;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

FILE: hdl/clhp_queue.sv
// two-entry queue between the front and back ends
`default_nettype none
module clhp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  clhp_pkg::t_item    i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_not_empty,
    output clhp_pkg::t_item    o_item
);
    import clhp_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/clhp_back.sv
// back end: header state machine, value accumulator and result register
`default_nettype none
module clhp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_not_empty,
    input  clhp_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_status,
    output logic [31:0]        o_body_length
);
    import clhp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_match_index, n_match_index;
    logic [31:0] r_acc, n_acc;
    logic        r_digit_seen, n_digit_seen;
    logic        r_pending_cr, n_pending_cr;
    t_status     r_decided, n_decided;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_len;

    logic        out_free;
    logic        take_last;
    logic        name_ok;
    logic        overflow;
    logic [31:0] acc_next;
    t_status     fin_status;

    // result register can take a new result when empty or drained this cycle
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_pop     = i_not_empty && (!i_item.last || out_free);
    assign take_last = o_pop && i_item.last;

    assign name_ok  = (r_match_index < 4'(NAME_LEN)) && i_item.name_hit[r_match_index];
    assign overflow = (r_acc > ACC_LIMIT) || ((r_acc == ACC_LIMIT) && (i_item.digit > DIGIT_LIMIT));
    assign acc_next = (r_acc << 3) + (r_acc << 1) + 32'(i_item.digit);

    always_comb begin
        n_phase       = r_phase;
        n_match_index = r_match_index;
        n_acc         = r_acc;
        n_digit_seen  = r_digit_seen;
        n_pending_cr  = r_pending_cr;
        n_decided     = r_decided;
        unique case (r_phase)
            PH_LEAD: begin
                if (i_item.is_ws || i_item.is_lf) begin
                    n_phase = PH_LEAD;
                end else if (i_item.name_hit[0]) begin
                    n_phase       = PH_NAME;
                    n_match_index = 4'd1;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_NAME: begin
                if (name_ok) begin
                    n_match_index = r_match_index + 4'd1;
                    if (r_match_index == 4'(NAME_LEN - 1)) begin
                        n_phase      = PH_VALUE;
                        n_acc        = '0;
                        n_digit_seen = 1'b0;
                        n_pending_cr = 1'b0;
                    end
                end else if (i_item.is_lf) begin
                    n_phase       = PH_LEAD;
                    n_match_index = '0;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (i_item.is_lf) begin
                    n_phase       = PH_LEAD;
                    n_match_index = '0;
                end
            end
            PH_VALUE: begin
                priority if (r_pending_cr) begin
                    n_pending_cr = 1'b0;
                    n_phase      = PH_DONE;
                    if (i_item.is_lf) begin
                        n_decided = r_digit_seen ? ST_FOUND : ST_MALFORMED;
                    end else begin
                        n_decided = ST_MALFORMED;
                    end
                end else if (i_item.is_lf) begin
                    n_phase   = PH_DONE;
                    n_decided = r_digit_seen ? ST_FOUND : ST_MALFORMED;
                end else if (i_item.is_cr) begin
                    n_pending_cr = 1'b1;
                end else if (i_item.is_digit) begin
                    if (overflow) begin
                        n_phase   = PH_DONE;
                        n_decided = ST_MALFORMED;
                    end else begin
                        n_acc        = acc_next;
                        n_digit_seen = 1'b1;
                    end
                end else if (i_item.is_ws && !r_digit_seen) begin
                    n_phase = PH_VALUE;
                end else begin
                    n_phase   = PH_DONE;
                    n_decided = ST_MALFORMED;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // a value line still open at the last byte ends there
    always_comb begin
        if (n_phase == PH_VALUE) begin
            fin_status = n_digit_seen ? ST_FOUND : ST_MALFORMED;
        end else begin
            fin_status = n_decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LEAD;
            r_match_index <= '0;
            r_acc         <= '0;
            r_digit_seen  <= 1'b0;
            r_pending_cr  <= 1'b0;
            r_decided     <= ST_NOT_FOUND;
            r_out_valid   <= 1'b0;
        end else begin
            if (take_last) begin
                r_phase       <= PH_LEAD;
                r_match_index <= '0;
                r_acc         <= '0;
                r_digit_seen  <= 1'b0;
                r_pending_cr  <= 1'b0;
                r_decided     <= ST_NOT_FOUND;
            end else if (o_pop) begin
                r_phase       <= n_phase;
                r_match_index <= n_match_index;
                r_acc         <= n_acc;
                r_digit_seen  <= n_digit_seen;
                r_pending_cr  <= n_pending_cr;
                r_decided     <= n_decided;
            end
            if (take_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_status <= fin_status;
            r_len    <= (fin_status == ST_FOUND) ? n_acc : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_body_length = r_len;

endmodule
`default_nettype wire

FILE: hdl/content_length_header_parser.sv
// top level of the content-length header parser
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_data_byte, i_is_last
//  out     | output    | o_out_valid / i_out_stall  | o_status, o_body_length
//
// one byte per cycle while no stalled result holds back a last byte; a byte passes the
// two-entry queue and the state machine, and the result register loads when the last byte
// leaves the queue. the state update and the acc*10+digit add are done on each byte as it leaves.
// reset is synchronous and active low and clears all control state.
// a stalled result holds back the next last byte and the bytes queued behind it; earlier bytes keep flowing.
`default_nettype none
module content_length_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_body_length
);
    import clhp_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  not_empty;
    t_item front_item;
    t_item back_item;

    clhp_front u_front (
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_push      (push),
        .o_item      (front_item),
        .i_full      (full)
    );

    clhp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_item      (back_item)
    );

    clhp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_not_empty   (not_empty),
        .i_item        (back_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_body_length (o_body_length)
    );

endmodule
`default_nettype wire

FILE: hdl/clhp_checker.sv
// port-level checks for the content-length header parser
`default_nettype none
module clhp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_body_length
);
    import clhp_pkg::*;

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_FOUND || o_status == ST_NOT_FOUND ||
                         o_status == ST_MALFORMED))
        else $error("result status code out of range");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_FOUND) |-> (o_body_length == 32'd0))
        else $error("length nonzero without a found header");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_body_length)))
        else $error("stalled result transaction changed");

endmodule

bind content_length_header_parser clhp_checker u_clhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_body_length (o_body_length)
);
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the content-length header parser
`timescale 1ns / 100ps
module tb;
    import clhp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_is_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [31:0] o_body_length;

    content_length_header_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_body_length (o_body_length)
    );

    // scanner state mirrored by the testbench
    t_phase      scan_phase;
    logic [3:0]  name_pos;
    logic [31:0] len_acc;
    logic        have_digit;
    logic        held_cr;
    t_status     verdict;

    t_status     verdict_q[$];
    logic [31:0] length_q[$];
    logic [7:0]  region_q[$];

    int src_idle_pct;
    int sink_idle_pct;
    int bytes_sent;
    int regions_sent;
    int results_seen;
    int found_n;
    int absent_n;
    int bad_n;
    int fail_count;
    int cycle_count;
    t_status     want_status;
    logic [31:0] want_length;

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] name_char(input int idx);
        return HDR_NAME[8*(NAME_LEN-1-idx) +: 8];
    endfunction

    task automatic clear_scan();
        scan_phase = PH_LEAD;
        name_pos   = '0;
        len_acc    = '0;
        have_digit = 1'b0;
        held_cr    = 1'b0;
        verdict    = ST_NOT_FOUND;
    endtask

    task automatic close_value();
        if (have_digit) verdict = ST_FOUND;
        else verdict = ST_MALFORMED;
        scan_phase = PH_DONE;
    endtask

    // advance the mirrored scanner by one accepted byte
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic       ws;
        logic [3:0] d;
        ws = (b == CH_SP) || (b == CH_TAB);
        d  = b[3:0];
        case (scan_phase)
            PH_LEAD: begin
                if (ws || b == CH_LF) begin
                    // still at line start
                end else if (b == name_char(0)) begin
                    scan_phase = PH_NAME;
                    name_pos   = 4'd1;
                end else begin
                    scan_phase = PH_SKIP;
                end
            end
            PH_NAME: begin
                if (name_pos < NAME_LEN && b == name_char(name_pos)) begin
                    name_pos = name_pos + 4'd1;
                    if (name_pos == NAME_LEN) begin
                        scan_phase = PH_VALUE;
                        len_acc    = '0;
                        have_digit = 1'b0;
                        held_cr    = 1'b0;
                    end
                end else if (b == CH_LF) begin
                    scan_phase = PH_LEAD;
                    name_pos   = '0;
                end else begin
                    scan_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (b == CH_LF) begin
                    scan_phase = PH_LEAD;
                    name_pos   = '0;
                end
            end
            PH_VALUE: begin
                if (held_cr) begin
                    // a cr is only stripped when the line ends right after it
                    held_cr = 1'b0;
                    if (b == CH_LF) close_value();
                    else begin
                        verdict    = ST_MALFORMED;
                        scan_phase = PH_DONE;
                    end
                end else if (b == CH_LF) begin
                    close_value();
                end else if (b == CH_CR) begin
                    held_cr = 1'b1;
                end else if (b >= CH_0 && b <= CH_9) begin
                    if (len_acc > ACC_LIMIT || (len_acc == ACC_LIMIT && d > DIGIT_LIMIT)) begin
                        verdict    = ST_MALFORMED;
                        scan_phase = PH_DONE;
                    end else begin
                        len_acc    = len_acc * 32'd10 + {28'd0, d};
                        have_digit = 1'b1;
                    end
                end else if (ws && !have_digit) begin
                    // blanks ahead of the digits
                end else begin
                    verdict    = ST_MALFORMED;
                    scan_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            if (scan_phase == PH_VALUE) close_value();
            verdict_q.push_back(verdict);
            length_q.push_back(verdict == ST_FOUND ? len_acc : 32'd0);
            case (verdict)
                ST_FOUND:     found_n++;
                ST_NOT_FOUND: absent_n++;
                default:      bad_n++;
            endcase
            clear_scan();
        end
    endtask

    // drive one byte; called just after a falling edge, returns just after a falling edge once the byte is accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_in_stall);
        scan_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) region_q.push_back(s[i]);
    endtask

    task automatic flush_region();
        for (int i = 0; i < region_q.size(); i++) send_byte(region_q[i], i == region_q.size() - 1);
        region_q.delete();
        regions_sent++;
    endtask

    task automatic send_region(input string s);
        add_text(s);
        flush_region();
    endtask

    function automatic string random_value();
        case ($urandom_range(7))
            0:       return "0";
            1:       return "4294967295";
            2:       return $sformatf("%0d", 64'd4294967296 + $urandom_range(5000));
            3:       return $sformatf("00%0d", $urandom);
            4:       return $sformatf("%0d", 32'd4294967290 + $urandom_range(5));
            default: return $sformatf("%0d", $urandom >> $urandom_range(31));
        endcase
    endfunction

    // one header line: mostly length lines, some of them broken, some other
    task automatic add_random_line(input bit final_line);
        int kind;
        int n;
        int pick;
        int name_at;
        kind = $urandom_range(99);
        if (kind < 70) begin
            n = $urandom_range(2);
            repeat (n) region_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
            name_at = region_q.size();
            add_text("Content-Length:");
            n = $urandom_range(2);
            repeat (n) region_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
            pick = (kind < 55) ? 0 : $urandom_range(1, 5);
            if (pick == 1) region_q[name_at + $urandom_range(NAME_LEN - 1)] = 8'($urandom_range(255));
            if (pick != 2) add_text(random_value());
            case (pick)
                3: region_q.push_back(8'($urandom_range(255)));
                4: begin
                    add_text(" ");
                    add_text(random_value());
                end
                5: add_text("\015x");
                default: begin
                end
            endcase
        end else if (kind < 85) begin
            add_text($sformatf("X-Tag%0d: %0d", $urandom_range(99), $urandom));
        end else begin
            n = $urandom_range(1, 12);
            repeat (n) region_q.push_back(8'($urandom_range(255)));
        end
        if (final_line && $urandom_range(2) == 0) begin
            if ($urandom_range(1)) region_q.push_back(CH_CR);
        end else begin
            if ($urandom_range(1)) region_q.push_back(CH_CR);
            region_q.push_back(CH_LF);
        end
    endtask

    task automatic test_found_lengths();
        send_region("Content-Length: 4294967295\015\n");
        send_region("Content-Length:0");
        send_region(" \tContent-Length:\t 7\nContent-Length: 9\n");
        send_region("X: 1\nContent-Length: 3");
        send_region("Content\nContent-Length:8\n");
        send_region("Content-Length: 12\015");
        send_region("Content-Length: 0004294967295\n");
    endtask

    task automatic test_absent_header();
        send_region("Host: x\015\n");
        send_region("Conte\015nt-Length: 5\n");
        send_region("content-length: 5\n");
        send_region("Content-Length 5\n");
        send_byte(CH_LF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_malformed_values();
        send_region("Content-Length: 4294967296");
        send_region("Content-Length: 42949672950\n");
        send_region("Content-Length: 12\015x\n");
        send_region("Content-Length: 12 \n");
        send_region("Content-Length: \015\n");
        send_region("Content-Length:\015");
        send_region("Content-Length: 1a\nContent-Length: 5\n");
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_bytes);
        int first_byte;
        int first_region;
        int lines;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        first_byte    = bytes_sent;
        first_region  = regions_sent;
        while (bytes_sent - first_byte < n_bytes || regions_sent - first_region < 20) begin
            lines = $urandom_range(1, 4);
            for (int j = 0; j < lines; j++) add_random_line(j == lines - 1);
            flush_region();
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    // compare each accepted result with the oldest expected transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d length=%0d",
                         $time, o_status, o_body_length);
                fail_count++;
            end else begin
                want_status = verdict_q.pop_front();
                want_length = length_q.pop_front();
                results_seen++;
                if (o_status !== want_status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, want_status, o_status);
                    fail_count++;
                end
                if (o_body_length !== want_length) begin
                    $display("%0t: body_length mismatch expected=%0d actual=%0d",
                             $time, want_length, o_body_length);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = 8'h00;
        i_is_last     = 1'b0;
        i_out_stall   = 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        bytes_sent    = 0;
        regions_sent  = 0;
        results_seen  = 0;
        found_n       = 0;
        absent_n      = 0;
        bad_n         = 0;
        fail_count    = 0;
        cycle_count   = 0;
        clear_scan();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct  = 21;
        sink_idle_pct = 88;
        test_found_lengths();
        test_absent_header();
        test_malformed_values();
        test_random_traffic(21, 88, 350);
        test_random_traffic(88, 21, 350);
        test_random_traffic(0, 0, 350);

        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d header regions, checked %0d results",
                 bytes_sent, regions_sent, results_seen);
        $display("lengths found %0d, header absent %0d, malformed or overflowing %0d",
                 found_n, absent_n, bad_n);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
